>>> hw/rtl/ips_pkg.sv
package ips_pkg;

    // field widths
    localparam int POS_W = 24;
    localparam int VEL_W = 16;
    localparam int SPD_W = 16;
    localparam int TF    = 16;

    // derived datapath widths
    localparam int OW   = POS_W + 1;
    localparam int VW   = (VEL_W > SPD_W) ? VEL_W : SPD_W;
    localparam int AW   = 2 * VW + 3;
    localparam int AM   = AW - 1;
    localparam int HW   = OW + VEL_W + 1;
    localparam int HM   = HW - 1;
    localparam int CW   = 2 * OW;
    localparam int H2W  = 2 * HM;
    localparam int ACW  = AM + CW;
    localparam int DW   = ((H2W > ACW) ? H2W : ACW) + 2;
    localparam int RW   = DW / 2;
    localparam int SN   = 2 * RW;
    localparam int NW   = ((HW > RW + 1) ? HW : RW + 1) + 1;
    localparam int NM   = NW - 1;
    localparam int MW   = NM + TF;
    localparam int TW   = POS_W + TF + 4;
    localparam int TM   = TW - 1;
    localparam int LW   = (MW > TM) ? MW : TM;
    localparam int PW   = TW + VEL_W;
    localparam int SHW  = PW - TF;
    localparam int SUMW = SHW + 1;

    // time clamp, 2^(POS_W+2+TF)
    localparam logic [LW-1:0] TMAX = {{(LW-1){1'b0}}, 1'b1} << (POS_W + 2 + TF);

    typedef enum logic [1:0] {
        ST_SOLVED  = 2'd0,
        ST_NO_ROOT = 2'd1,
        ST_DEGEN   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [POS_W-1:0] pursuer_x;
        logic signed [POS_W-1:0] pursuer_y;
        logic        [SPD_W-1:0] pursuer_speed;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] target_z;
        logic signed [VEL_W-1:0] target_vx;
        logic signed [VEL_W-1:0] target_vy;
        logic signed [VEL_W-1:0] target_vz;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] aim_x;
        logic signed [POS_W-1:0] aim_y;
        logic signed [POS_W-1:0] aim_z;
        t_status                 solve_status;
    } t_out;

    // target position and velocity carried down the pipe
    typedef struct packed {
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] tz;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vz;
    } t_geo;

    typedef struct packed {
        t_status              status;
        logic                 a_neg;
        logic signed [HW-1:0] h;
        logic        [AM-1:0] a_mag;
        t_geo                 geo;
    } t_sq_side;

    typedef struct packed {
        t_status       status;
        logic          t_neg;
        logic [AM-1:0] a_mag;
        t_geo          geo;
    } t_dv_side;

endpackage

>>> hw/rtl/intercept_point_solver_core.sv
// pipeline: square root chain then divider chain
// (43 square root cells, one per root bit, then 60 divider cells, one per quotient bit)
// throughput: one item per cycle; the whole pipe holds while an output beat waits
// reset (synchronous, active low) clears the valid flags of every stage, data is not reset
module intercept_point_solver_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ips_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output ips_pkg::t_out o_res
);

    localparam int POS_W = ips_pkg::POS_W;
    localparam int VEL_W = ips_pkg::VEL_W;
    localparam int SPD_W = ips_pkg::SPD_W;
    localparam int OW    = ips_pkg::OW;
    localparam int AW    = ips_pkg::AW;
    localparam int AM    = ips_pkg::AM;
    localparam int HW    = ips_pkg::HW;
    localparam int HM    = ips_pkg::HM;
    localparam int CW    = ips_pkg::CW;
    localparam int DW    = ips_pkg::DW;
    localparam int RW    = ips_pkg::RW;
    localparam int SN    = ips_pkg::SN;
    localparam int NW    = ips_pkg::NW;
    localparam int NM    = ips_pkg::NM;
    localparam int MW    = ips_pkg::MW;
    localparam int TF    = ips_pkg::TF;
    localparam int TW    = ips_pkg::TW;
    localparam int TM    = ips_pkg::TM;
    localparam int LW    = ips_pkg::LW;
    localparam int PW    = ips_pkg::PW;
    localparam int SHW   = ips_pkg::SHW;
    localparam int SUMW  = ips_pkg::SUMW;

    logic en;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_vo;

    // stage 1: offsets
    ips_pkg::t_geo          r_g1;
    logic [SPD_W-1:0]       r_s1;
    logic signed [OW-1:0]   r_ox;
    logic signed [OW-1:0]   r_oy;

    // stage 2: small products
    ips_pkg::t_geo                r_g2;
    logic signed [2*VEL_W-1:0]    r_vx2, r_vy2, r_vz2;
    logic [2*SPD_W-1:0]           r_s2;
    logic signed [OW+VEL_W-1:0]   r_hx, r_hy;
    logic signed [2*OW-1:0]       r_cx, r_cy;

    // stage 3: A, h, C
    ips_pkg::t_geo        r_g3;
    logic signed [AW-1:0] r_a3;
    logic signed [HW-1:0] r_h3;
    logic [CW-1:0]        r_c3;
    logic [HM-1:0]        h_mag;
    logic [AM-1:0]        a_mag;

    // stages 4-5: wide products in flight
    ips_pkg::t_geo        r_g4, r_g5;
    logic signed [AW-1:0] r_a4, r_a5;
    logic signed [HW-1:0] r_h4, r_h5;
    logic [2*HM-1:0]      h2;
    logic [AM+CW-1:0]     ac;

    // stage 6: discriminant
    logic signed [DW-1:0] disc;
    logic [SN-1:0]        r_rad6;
    ips_pkg::t_sq_side    r_sq6;
    ips_pkg::t_status     st6;

    // square root chain
    logic              sq_vld  [RW+1];
    logic [SN-1:0]     sq_rad  [RW+1];
    logic [RW:0]       sq_rem  [RW+1];
    logic [RW-1:0]     sq_root [RW+1];
    ips_pkg::t_sq_side sq_side [RW+1];

    // stage 7: root choice
    logic signed [NW-1:0] n1, n2, nsel, nabs;
    logic                 pick1;
    logic [MW-1:0]        r_num7;
    ips_pkg::t_dv_side    r_dv7;

    // divider chain
    logic              dv_vld  [MW+1];
    logic [MW-1:0]     dv_num  [MW+1];
    logic [AM-1:0]     dv_rem  [MW+1];
    logic [MW-1:0]     dv_q    [MW+1];
    ips_pkg::t_dv_side dv_side [MW+1];

    // stage 8: clamped signed time
    logic [LW-1:0]        qx, tmag;
    logic signed [TW-1:0] r_t8;
    ips_pkg::t_status     r_st8;
    ips_pkg::t_geo        r_g8;

    // stage 9: time times velocity
    logic signed [PW-1:0] r_px, r_py, r_pz;
    ips_pkg::t_status     r_st9;
    ips_pkg::t_geo        r_g9;

    // output
    ips_pkg::t_out r_out;
    ips_pkg::t_out n_out;

    function automatic logic signed [POS_W-1:0] sat_coord(
        input logic signed [PW-1:0]    p,
        input logic signed [POS_W-1:0] tgt
    );
        logic signed [SUMW-1:0] s;
        logic signed [SUMW-1:0] lo;
        logic signed [SUMW-1:0] hi;
        logic signed [SHW-1:0]  sh;
        sh = p[PW-1:TF];
        lo = -(SUMW'(1) <<< (POS_W - 1));
        hi = (SUMW'(1) <<< (POS_W - 1)) - SUMW'(1);
        s  = SUMW'(sh) + SUMW'(tgt);
        if (s < lo) begin
            s = lo;
        end else if (s > hi) begin
            s = hi;
        end
        return s[POS_W-1:0];
    endfunction

    // whole pipe moves unless the output beat is held
    assign en      = !r_vo || i_ready;
    assign o_ready = en;
    assign o_valid = r_vo;
    assign o_res   = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= sq_vld[RW];
            r_v8 <= dv_vld[MW];
            r_v9 <= r_v8;
            r_vo <= r_v9;
        end
    end

    // stage 1: capture beat and form horizontal offset
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1.tx <= i_item.target_x;
            r_g1.ty <= i_item.target_y;
            r_g1.tz <= i_item.target_z;
            r_g1.vx <= i_item.target_vx;
            r_g1.vy <= i_item.target_vy;
            r_g1.vz <= i_item.target_vz;
            r_s1    <= i_item.pursuer_speed;
            r_ox    <= {i_item.pursuer_x[POS_W-1], i_item.pursuer_x}
                     - {i_item.target_x[POS_W-1], i_item.target_x};
            r_oy    <= {i_item.pursuer_y[POS_W-1], i_item.pursuer_y}
                     - {i_item.target_y[POS_W-1], i_item.target_y};
        end
    end

    // stage 2: squares and dot product terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g2  <= r_g1;
            r_vx2 <= r_g1.vx * r_g1.vx;
            r_vy2 <= r_g1.vy * r_g1.vy;
            r_vz2 <= r_g1.vz * r_g1.vz;
            r_s2  <= r_s1 * r_s1;
            r_hx  <= r_ox * r_g1.vx;
            r_hy  <= r_oy * r_g1.vy;
            r_cx  <= r_ox * r_ox;
            r_cy  <= r_oy * r_oy;
        end
    end

    // stage 3: quadratic coefficients
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g3 <= r_g2;
            r_a3 <= AW'(r_vx2) + AW'(r_vy2) + AW'(r_vz2)
                  - $signed({{(AW-2*SPD_W){1'b0}}, r_s2});
            r_h3 <= HW'(r_hx) + HW'(r_hy);
            r_c3 <= $unsigned(r_cx) + $unsigned(r_cy);
        end
    end

    always_comb begin
        h_mag = r_h3[HW-1] ? HM'(-r_h3) : r_h3[HM-1:0];
        a_mag = r_a3[AW-1] ? AM'(-r_a3) : r_a3[AM-1:0];
    end

    // h squared and |A| times C
    ips_mul #(.A_W(HM), .B_W(HM)) u_mul_hh (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (h_mag),
        .i_b   (h_mag),
        .o_p   (h2)
    );

    ips_mul #(.A_W(AM), .B_W(CW)) u_mul_ac (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (a_mag),
        .i_b   (r_c3),
        .o_p   (ac)
    );

    // carry coefficients alongside the multipliers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g4 <= r_g3;
            r_a4 <= r_a3;
            r_h4 <= r_h3;
            r_g5 <= r_g4;
            r_a5 <= r_a4;
            r_h5 <= r_h4;
        end
    end

    // stage 6: discriminant and status
    always_comb begin
        if (r_a5[AW-1]) begin
            disc = $signed(DW'(h2)) + $signed(DW'(ac));
        end else begin
            disc = $signed(DW'(h2)) - $signed(DW'(ac));
        end
        if (r_a5 == '0) begin
            st6 = ips_pkg::ST_DEGEN;
        end else if (disc[DW-1]) begin
            st6 = ips_pkg::ST_NO_ROOT;
        end else begin
            st6 = ips_pkg::ST_SOLVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad6       <= disc[SN-1:0];
            r_sq6.status <= st6;
            r_sq6.a_neg  <= r_a5[AW-1];
            r_sq6.h      <= r_h5;
            r_sq6.a_mag  <= r_a5[AW-1] ? AM'(-r_a5) : r_a5[AM-1:0];
            r_sq6.geo    <= r_g5;
        end
    end

    // square root chain, one result bit per cell
    assign sq_vld[0]  = r_v6;
    assign sq_rad[0]  = r_rad6;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_sq6;

    for (genvar k = 0; k < RW; k++) begin : g_sq
        ips_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_vld   (sq_vld[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // stage 7: minus root if that gives a non-negative time, else plus root
    always_comb begin
        n1    = NW'(sq_side[RW].h) - $signed(NW'(sq_root[RW]));
        n2    = NW'(sq_side[RW].h) + $signed(NW'(sq_root[RW]));
        pick1 = (n1 == '0) || (n1[NW-1] == sq_side[RW].a_neg);
        nsel  = pick1 ? n1 : n2;
        nabs  = nsel[NW-1] ? -nsel : nsel;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num7       <= {nabs[NM-1:0], {TF{1'b0}}};
            r_dv7.status <= sq_side[RW].status;
            r_dv7.t_neg  <= nsel[NW-1] != sq_side[RW].a_neg;
            r_dv7.a_mag  <= sq_side[RW].a_mag;
            r_dv7.geo    <= sq_side[RW].geo;
        end
    end

    // divider chain, one quotient bit per cell
    assign dv_vld[0]  = r_v7;
    assign dv_num[0]  = r_num7;
    assign dv_rem[0]  = '0;
    assign dv_q[0]    = '0;
    assign dv_side[0] = r_dv7;

    for (genvar k = 0; k < MW; k++) begin : g_dv
        ips_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[k]),
            .i_num   (dv_num[k]),
            .i_rem   (dv_rem[k]),
            .i_q     (dv_q[k]),
            .i_side  (dv_side[k]),
            .o_vld   (dv_vld[k+1]),
            .o_num   (dv_num[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_q     (dv_q[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // stage 8: clamp and sign the time
    always_comb begin
        qx   = LW'(dv_q[MW]);
        tmag = (qx > ips_pkg::TMAX) ? ips_pkg::TMAX : qx;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t8  <= dv_side[MW].t_neg ? -$signed({1'b0, tmag[TM-1:0]})
                                       : $signed({1'b0, tmag[TM-1:0]});
            r_st8 <= dv_side[MW].status;
            r_g8  <= dv_side[MW].geo;
        end
    end

    // stage 9: displacement products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px  <= r_t8 * r_g8.vx;
            r_py  <= r_t8 * r_g8.vy;
            r_pz  <= r_t8 * r_g8.vz;
            r_st9 <= r_st8;
            r_g9  <= r_g8;
        end
    end

    // output: add target, saturate, or pass target through on a flagged case
    always_comb begin
        n_out.solve_status = r_st9;
        if (r_st9 == ips_pkg::ST_SOLVED) begin
            n_out.aim_x = sat_coord(r_px, r_g9.tx);
            n_out.aim_y = sat_coord(r_py, r_g9.ty);
            n_out.aim_z = sat_coord(r_pz, r_g9.tz);
        end else begin
            n_out.aim_x = r_g9.tx;
            n_out.aim_y = r_g9.ty;
            n_out.aim_z = r_g9.tz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/ips_mul.sv
module ips_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int AL = A_W / 2;
    localparam int AH = A_W - AL;
    localparam int BL = B_W / 2;
    localparam int BH = B_W - BL;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [A_W+B_W-1:0] r_p;
    logic [A_W+B_W-1:0] n_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0] * i_b[B_W-1:BL];
            r_hl <= i_a[A_W-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[A_W-1:AL] * i_b[B_W-1:BL];
        end
    end

    // recombine
    always_comb begin
        n_p = (A_W+B_W)'(r_ll)
            + ((A_W+B_W)'(r_lh) << BL)
            + ((A_W+B_W)'(r_hl) << AL)
            + ((A_W+B_W)'(r_hh) << (AL + BL));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> hw/rtl/ips_sqrt_cell.sv
module ips_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [ips_pkg::SN-1:0] i_rad,
    input  logic [ips_pkg::RW:0]   i_rem,
    input  logic [ips_pkg::RW-1:0] i_root,
    input  ips_pkg::t_sq_side      i_side,
    output logic                 o_vld,
    output logic [ips_pkg::SN-1:0] o_rad,
    output logic [ips_pkg::RW:0]   o_rem,
    output logic [ips_pkg::RW-1:0] o_root,
    output ips_pkg::t_sq_side      o_side
);

    logic                      r_vld;
    logic [ips_pkg::SN-1:0]    r_rad;
    logic [ips_pkg::RW:0]      r_rem;
    logic [ips_pkg::RW-1:0]    r_root;
    ips_pkg::t_sq_side         r_side;
    logic [ips_pkg::RW+2:0]    rem_sh;
    logic [ips_pkg::RW+2:0]    trial;
    logic [ips_pkg::RW+2:0]    diff;
    logic                      take;

    // one root bit: bring in two radicand bits and try (4 root + 1)
    always_comb begin
        rem_sh = {i_rem, i_rad[ips_pkg::SN-1:ips_pkg::SN-2]};
        trial  = {1'b0, i_root, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[ips_pkg::SN-3:0], 2'b00};
            r_rem  <= take ? diff[ips_pkg::RW:0] : rem_sh[ips_pkg::RW:0];
            r_root <= {i_root[ips_pkg::RW-2:0], take};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

>>> hw/rtl/ips_div_cell.sv
module ips_div_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [ips_pkg::MW-1:0] i_num,
    input  logic [ips_pkg::AM-1:0] i_rem,
    input  logic [ips_pkg::MW-1:0] i_q,
    input  ips_pkg::t_dv_side      i_side,
    output logic                   o_vld,
    output logic [ips_pkg::MW-1:0] o_num,
    output logic [ips_pkg::AM-1:0] o_rem,
    output logic [ips_pkg::MW-1:0] o_q,
    output ips_pkg::t_dv_side      o_side
);

    logic                   r_vld;
    logic [ips_pkg::MW-1:0] r_num;
    logic [ips_pkg::AM-1:0] r_rem;
    logic [ips_pkg::MW-1:0] r_q;
    ips_pkg::t_dv_side      r_side;
    logic [ips_pkg::AM:0]   rem_sh;
    logic [ips_pkg::AM:0]   dvs;
    logic [ips_pkg::AM:0]   diff;
    logic                   take;

    // one quotient bit, restoring step against |a|
    always_comb begin
        rem_sh = {i_rem, i_num[ips_pkg::MW-1]};
        dvs    = {1'b0, i_side.a_mag};
        diff   = rem_sh - dvs;
        take   = (rem_sh >= dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= {i_num[ips_pkg::MW-2:0], 1'b0};
            r_rem  <= take ? diff[ips_pkg::AM-1:0] : rem_sh[ips_pkg::AM-1:0];
            r_q    <= {i_q[ips_pkg::MW-2:0], take};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

>>> dv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POS_W = ips_pkg::POS_W;
    localparam int VEL_W = ips_pkg::VEL_W;
    localparam int SPD_W = ips_pkg::SPD_W;
    localparam int TF    = ips_pkg::TF;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    ips_pkg::t_in   i_item = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    ips_pkg::t_out  o_res;

    ips_pkg::t_out  aim_queue[$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    quiet_cycles = 0;

    intercept_point_solver_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    // saturate a wide coordinate to the position range
    function automatic logic signed [POS_W-1:0] clamp_pos(logic signed [127:0] p);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        lo = -(128'sd1 <<< (POS_W - 1));
        hi = (128'sd1 <<< (POS_W - 1)) - 1;
        if (p < lo) p = lo;
        if (p > hi) p = hi;
        return p[POS_W-1:0];
    endfunction

    // intercept point from one query, exact wide integer arithmetic
    function automatic ips_pkg::t_out solve_intercept(ips_pkg::t_in q);
        ips_pkg::t_out       res;
        logic signed [127:0] ox, oy, a, h, c, disc, n, tq, sx, sy, sz;
        logic        [127:0] root, cand, na, ma, quot, tmax;
        ox = 128'(q.pursuer_x) - 128'(q.target_x);
        oy = 128'(q.pursuer_y) - 128'(q.target_y);
        a  = 128'(q.target_vx) * 128'(q.target_vx) + 128'(q.target_vy) * 128'(q.target_vy)
           + 128'(q.target_vz) * 128'(q.target_vz)
           - $signed({112'd0, q.pursuer_speed}) * $signed({112'd0, q.pursuer_speed});
        h  = ox * 128'(q.target_vx) + oy * 128'(q.target_vy);
        c  = ox * ox + oy * oy;
        res.aim_x = q.target_x;
        res.aim_y = q.target_y;
        res.aim_z = q.target_z;
        res.solve_status = ips_pkg::ST_SOLVED;
        if (a == 0) begin
            res.solve_status = ips_pkg::ST_DEGEN;
            return res;
        end
        disc = h * h - a * c;
        if (disc < 0) begin
            res.solve_status = ips_pkg::ST_NO_ROOT;
            return res;
        end
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= disc) root = cand;
        end
        // take h minus root when it gives a time not in the past, else h plus root
        n = h - $signed(root);
        if (!(n == 0 || ((n < 0) == (a < 0)))) n = h + $signed(root);
        na = (n < 0) ? -n : n;
        ma = (a < 0) ? -a : a;
        quot = (na << TF) / ma;
        tmax = 128'd1 << (POS_W + 2 + TF);
        if (quot > tmax) quot = tmax;
        tq = $signed(quot);
        if ((n < 0) != (a < 0)) tq = -tq;
        sx = (tq * 128'(q.target_vx)) >>> TF;
        sy = (tq * 128'(q.target_vy)) >>> TF;
        sz = (tq * 128'(q.target_vz)) >>> TF;
        res.aim_x = clamp_pos(sx + 128'(q.target_x));
        res.aim_y = clamp_pos(sy + 128'(q.target_y));
        res.aim_z = clamp_pos(sz + 128'(q.target_z));
        return res;
    endfunction

    // send one query beat, idling first at random
    task automatic send_query(ips_pkg::t_in q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= q;
        do @(posedge i_clk); while (!o_ready);
        aim_queue.push_back(solve_intercept(q));
    endtask

    function automatic ips_pkg::t_in make_query(
        int px, int py, int s, int tx, int ty, int tz, int vx, int vy, int vz);
        ips_pkg::t_in q;
        q.pursuer_x = POS_W'(px); q.pursuer_y = POS_W'(py); q.pursuer_speed = SPD_W'(s);
        q.target_x = POS_W'(tx); q.target_y = POS_W'(ty); q.target_z = POS_W'(tz);
        q.target_vx = VEL_W'(vx); q.target_vy = VEL_W'(vy); q.target_vz = VEL_W'(vz);
        return q;
    endfunction

    // random query: raw bits or a plausible chase geometry
    function automatic ips_pkg::t_in rand_query();
        ips_pkg::t_in q;
        logic [223:0] raw;
        int           span;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(ips_pkg::t_in)-1:0];
        if ($urandom_range(99) < 65) begin
            span = (1 << $urandom_range(4, 23)) - 1;
            q.pursuer_x = POS_W'(q.target_x + $signed($urandom_range(2 * span) - span));
            q.pursuer_y = POS_W'(q.target_y + $signed($urandom_range(2 * span) - span));
            span = (1 << $urandom_range(1, 15)) - 1;
            q.target_vx = VEL_W'($signed($urandom_range(2 * span) - span));
            q.target_vy = VEL_W'($signed($urandom_range(2 * span) - span));
            q.target_vz = VEL_W'($signed($urandom_range(2 * span) - span));
            q.pursuer_speed = SPD_W'($urandom_range(0, 2 * span));
            if ($urandom_range(9) == 0) q.target_vz = '0;
        end
        return q;
    endfunction

    // result check and receiver stalls
    always @(posedge i_clk) begin
        ips_pkg::t_out exp_aim;
        if (i_rst_n && o_valid && i_ready) begin
            if (aim_queue.size() == 0) begin
                $error("result beat with no query outstanding");
                errors++;
            end else begin
                exp_aim = aim_queue.pop_front();
                if (o_res.aim_x !== exp_aim.aim_x) begin
                    $error("aim_x exp %0d act %0d", exp_aim.aim_x, o_res.aim_x);
                    errors++;
                end
                if (o_res.aim_y !== exp_aim.aim_y) begin
                    $error("aim_y exp %0d act %0d", exp_aim.aim_y, o_res.aim_y);
                    errors++;
                end
                if (o_res.aim_z !== exp_aim.aim_z) begin
                    $error("aim_z exp %0d act %0d", exp_aim.aim_z, o_res.aim_z);
                    errors++;
                end
                if (o_res.solve_status !== exp_aim.solve_status) begin
                    $error("solve_status exp %0d act %0d",
                           exp_aim.solve_status, o_res.solve_status);
                    errors++;
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // extremes, degenerate and rootless cases, both root choices, saturation
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_query('0);
        send_query('1);
        send_query(make_query(0, 0, 0, 5, 6, 7, 0, 0, 0));
        send_query(make_query(0, 0, 5, 1, 2, 3, 3, 4, 0));
        send_query(make_query(100, 0, 10, 0, 0, 0, 0, 20, 0));
        send_query(make_query(100, 0, 30, 0, 0, 0, 10, 0, 5));
        send_query(make_query(100, 0, 10, 0, 0, 0, 20, 0, 0));
        send_query(make_query(100, 0, 10, 0, 0, 0, -20, 0, 0));
        send_query(make_query(-500, 300, 0, 0, 0, 0, 1, 0, 0));
        send_query(make_query(8388607, 8388607, 0, -8388608, -8388608, -8388608,
                              1, 1, 0));
        send_query(make_query(-8388608, -8388608, 65535, 8388607, 8388607, 8388607,
                              32767, -32768, 32767));
        send_query(make_query(-8388608, 8388607, 1, 8388607, -8388608, 0,
                              -32768, 32767, -32768));
        send_query(make_query(0, 0, 65535, 0, 0, 0, -32768, -32768, -32768));
        send_query(make_query(1000, 1000, 40000, -1000, -1000, 8388607,
                              32767, 32767, 32767));
        send_query(make_query(7, -7, 65535, 7, -7, -8388608, 0, 0, 0));
        send_query(make_query(0, 0, 3, 10, 0, 0, 0, 4, 0));
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) send_query(rand_query());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500, 0, 0);
        test_random(500, 77, 0);
        test_random(500, 0, 77);
        test_random(500, 30, 30);
        i_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (aim_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/ips_pkg.sv
hw/rtl/ips_mul.sv
hw/rtl/ips_sqrt_cell.sv
hw/rtl/ips_div_cell.sv
hw/rtl/intercept_point_solver_core.sv
dv/tb_top.sv
